>>> design/sttk_pkg.sv
// Shared types, character codes and class functions for the source text tokenizer.
// No dependencies; imported by sttk_step and source_text_tokenizer_unit.
package sttk_pkg;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_STRING  = 2'd1;
	localparam logic [1:0] MODE_COMMENT = 2'd2;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int MAX_RES = 2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] quote;
		logic [7:0] held;
		logic       held_valid;
		logic       held_op;
	} state_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_end;
		logic       text_done;
		logic       last;
	} result_t;

	localparam state_t STATE_RESET = '{mode: MODE_NORMAL, quote: 8'h00, held: 8'h00,
		held_valid: 1'b0, held_op: 1'b0};

	function automatic logic is_pair_op(input logic [7:0] c);
		return c == 8'h21 || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h3A ||
			c == 8'h2F || c == 8'h3E || c == 8'h3C || c == CH_EQ || c == CH_CARET;
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return c == 8'h26 || c == 8'h7C || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
			c == 8'h7D || c == 8'h28 || c == 8'h29 || c == 8'h2E || c == 8'h2C ||
			c == 8'h3B || c == CH_BSLASH;
	endfunction

	function automatic result_t mk_res(input logic [7:0] b, input logic v, input logic e);
		result_t r;
		r.token_byte = b;
		r.byte_valid = v;
		r.token_end  = e;
		r.text_done  = 1'b0;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

>>> design/sttk_step.sv
// Next-state and result logic for one text byte of the tokenizer.
// Depends on sttk_pkg (state_t, result_t, character codes).
module sttk_step (
	input  sttk_pkg::state_t  cur,
	input  logic [7:0]        c,
	input  logic              fin,
	output sttk_pkg::state_t  nxt,
	output sttk_pkg::result_t res [sttk_pkg::MAX_RES],
	output logic [1:0]        n
);
	import sttk_pkg::*;

	state_t     st;
	result_t    r [MAX_RES];
	logic [1:0] cnt;
	logic [1:0] cm1;
	logic       keep;

	always_comb begin
		st   = cur;
		r[0] = mk_res(8'h00, 1'b0, 1'b0);
		r[1] = mk_res(8'h00, 1'b0, 1'b0);
		cnt  = 2'd0;
		keep = 1'b1;

		if (st.mode == MODE_COMMENT) begin
			if (c == CH_NL)
				st.mode = (st.quote != 8'h00) ? MODE_STRING : MODE_NORMAL;
			keep = 1'b0;
		end else if (c == CH_HASH) begin
			st.mode = MODE_COMMENT;
			keep = 1'b0;
		end

		if (keep && st.held_valid && st.held_op) begin
			if (c == CH_EQ) begin
				r[cnt[0]] = mk_res(st.held, 1'b1, 1'b0);
				cnt = cnt + 2'd1;
				r[cnt[0]] = mk_res(c, 1'b1, 1'b1);
				cnt = cnt + 2'd1;
				keep = 1'b0;
			end else begin
				r[cnt[0]] = mk_res(st.held, 1'b1, 1'b1);
				cnt = cnt + 2'd1;
			end
			st.held_valid = 1'b0;
			st.held_op = 1'b0;
		end

		if (keep) begin
			if (st.mode == MODE_STRING) begin
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b0);
					cnt = cnt + 2'd1;
				end
				st.held = c;
				st.held_valid = 1'b1;
				st.held_op = 1'b0;
				if (c == st.quote) begin
					r[cnt[0]] = mk_res(c, 1'b1, 1'b1);
					cnt = cnt + 2'd1;
					st.held_valid = 1'b0;
					st.mode = MODE_NORMAL;
					st.quote = 8'h00;
				end
			end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				st.mode = MODE_STRING;
				st.quote = c;
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b0);
					cnt = cnt + 2'd1;
				end
				st.held = c;
				st.held_valid = 1'b1;
				st.held_op = 1'b0;
			end else if (is_pair_op(c)) begin
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b1);
					cnt = cnt + 2'd1;
				end
				st.held = c;
				st.held_valid = 1'b1;
				st.held_op = 1'b1;
			end else if (is_single(c)) begin
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b1);
					cnt = cnt + 2'd1;
				end
				st.held_valid = 1'b0;
				st.held_op = 1'b0;
				r[cnt[0]] = mk_res(c, 1'b1, 1'b1);
				cnt = cnt + 2'd1;
			end else if (c == CH_SPACE || c == CH_NL) begin
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b1);
					cnt = cnt + 2'd1;
				end
				st.held_valid = 1'b0;
				st.held_op = 1'b0;
			end else begin
				if (st.held_valid) begin
					r[cnt[0]] = mk_res(st.held, 1'b1, 1'b0);
					cnt = cnt + 2'd1;
				end
				st.held = c;
				st.held_valid = 1'b1;
				st.held_op = 1'b0;
			end
		end

		if (fin) begin
			if (st.held_valid) begin
				r[cnt[0]] = mk_res(st.held, 1'b1, 1'b1);
				cnt = cnt + 2'd1;
			end
			if (cnt == 2'd0) begin
				r[0] = mk_res(8'h00, 1'b0, 1'b0);
				cnt = 2'd1;
			end
			cm1 = cnt - 2'd1;
			r[cm1[0]].text_done = 1'b1;
			st = STATE_RESET;
		end

		cm1 = cnt - 2'd1;
		if (cnt != 2'd0)
			r[cm1[0]].last = 1'b1;

		nxt = st;
		res = r;
		n   = cnt;
	end

endmodule

>>> design/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: input register, step logic, result buffer.
// Depends on sttk_pkg and sttk_step.
//
//   channel | handshake            | beat payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | text_byte, is_final
//   out     | out_valid / out_ready| token_byte, byte_valid, token_end, text_done, last
//
// An input beat is registered, then processed by the step logic into a two-entry result
// buffer; one byte per cycle is sustained while each byte yields at most one result and
// out_ready stays high. A byte yielding two results holds the step while the buffer drains.
// arst_n clears the tokenizer state and the valid flags of the input register and the buffer.
// Output stalls back up through the buffer and input register to in_ready.
module source_text_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] token_byte,
	output logic       byte_valid,
	output logic       token_end,
	output logic       text_done,
	output logic       last
);
	import sttk_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	state_t     st_q;
	state_t     st_nxt;
	result_t    res [MAX_RES];
	logic [1:0] n;

	result_t    buf_q [MAX_RES];
	logic [1:0] cnt_q;
	logic       head_q;

	logic       take;
	logic       advance;
	result_t    cur_res;

	sttk_step u_step (
		.cur (st_q),
		.c   (byte_s1),
		.fin (final_s1),
		.nxt (st_nxt),
		.res (res),
		.n   (n)
	);

	assign out_valid = cnt_q != 2'd0;
	assign take      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign advance   = v_s1 && take;
	assign in_ready  = !v_s1 || advance;

	assign cur_res    = buf_q[head_q];
	assign token_byte = cur_res.token_byte;
	assign byte_valid = cur_res.byte_valid;
	assign token_end  = cur_res.token_end;
	assign text_done  = cur_res.text_done;
	assign last       = cur_res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= text_byte;
			final_s1 <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= STATE_RESET;
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (advance) begin
			st_q   <= st_nxt;
			cnt_q  <= n;
			head_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buf_q[0] <= res[0];
			buf_q[1] <= res[1];
		end
	end

endmodule

>>> bench/tb.sv
// Self-checking bench for source_text_tokenizer_unit: directed texts, then random token streams.
// Expected token bytes come from a behavioral tokenizer kept in this file; uses sttk_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sttk_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	typedef enum logic [2:0] {
		CL_WORD, CL_PAIR, CL_SINGLE, CL_QUOTE, CL_SPACE, CL_HASH
	} char_class_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       is_final;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] token_byte;
	logic       byte_valid;
	logic       token_end;
	logic       text_done;
	logic       last;

	logic [1:0] tk_mode;
	logic [7:0] tk_quote;
	logic [7:0] tk_held;
	logic       tk_held_v;
	logic       tk_held_op;
	result_t    step_res [MAX_RES];
	int         step_n;
	result_t    token_q [$];

	bit idle_on;
	int stall_left;
	int quiet_cycles;
	int n_errors;
	int n_bytes;
	int n_texts;
	int n_checked;
	int n_tokens;

	source_text_tokenizer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.is_final  (is_final),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.token_byte(token_byte),
		.byte_valid(byte_valid),
		.token_end (token_end),
		.text_done (text_done),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic char_class_t classify(input logic [7:0] c);
		case (c)
			CH_SQUOTE, CH_DQUOTE: return CL_QUOTE;
			CH_HASH: return CL_HASH;
			CH_SPACE, CH_NL: return CL_SPACE;
			"!", "+", "-", "*", ":", "/", ">", "<", CH_EQ, CH_CARET: return CL_PAIR;
			"&", "|", "[", "]", "{", "}", "(", ")", ".", ",", ";", CH_BSLASH: return CL_SINGLE;
			default: return CL_WORD;
		endcase
	endfunction

	task automatic push_res(input logic [7:0] b, input logic v, input logic e);
		if (step_n < MAX_RES) begin
			step_res[step_n] = '{b, v, e, 1'b0, 1'b0};
			step_n++;
		end
	endtask

	task automatic extend_token(input logic [7:0] c);
		if (tk_held_v)
			push_res(tk_held, 1'b1, 1'b0);
		tk_held = c;
		tk_held_v = 1'b1;
		tk_held_op = 1'b0;
	endtask

	task automatic close_token();
		if (tk_held_v)
			push_res(tk_held, 1'b1, 1'b1);
		tk_held_v = 1'b0;
		tk_held_op = 1'b0;
	endtask

	task automatic scan_char(input logic [7:0] c);
		char_class_t cl;
		cl = classify(c);
		if (tk_mode == MODE_STRING) begin
			extend_token(c);
			if (c == tk_quote) begin
				close_token();
				tk_mode = MODE_NORMAL;
				tk_quote = 8'h00;
			end
		end else if (cl == CL_QUOTE) begin
			tk_mode = MODE_STRING;
			tk_quote = c;
			extend_token(c);
		end else if (cl == CL_PAIR) begin
			close_token();
			tk_held = c;
			tk_held_v = 1'b1;
			tk_held_op = 1'b1;
		end else if (cl == CL_SINGLE) begin
			close_token();
			push_res(c, 1'b1, 1'b1);
		end else if (cl == CL_SPACE) begin
			close_token();
		end else begin
			extend_token(c);
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic fin);
		bit keep;
		keep = 1'b1;
		step_n = 0;
		if (tk_mode == MODE_COMMENT) begin
			if (c == CH_NL)
				tk_mode = (tk_quote != 8'h00) ? MODE_STRING : MODE_NORMAL;
			keep = 1'b0;
		end else if (c == CH_HASH) begin
			tk_mode = MODE_COMMENT;
			keep = 1'b0;
		end
		if (keep && tk_held_v && tk_held_op) begin
			if (c == CH_EQ) begin
				push_res(tk_held, 1'b1, 1'b0);
				push_res(c, 1'b1, 1'b1);
				keep = 1'b0;
			end else begin
				push_res(tk_held, 1'b1, 1'b1);
			end
			tk_held_v = 1'b0;
			tk_held_op = 1'b0;
		end
		if (keep)
			scan_char(c);
		if (fin) begin
			close_token();
			if (step_n == 0)
				push_res(8'h00, 1'b0, 1'b0);
			step_res[step_n - 1].text_done = 1'b1;
			tk_mode = MODE_NORMAL;
			tk_quote = 8'h00;
			tk_held = 8'h00;
			tk_held_v = 1'b0;
			tk_held_op = 1'b0;
			n_texts++;
		end
		if (step_n > 0)
			step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			token_q.insert(token_q.size(), step_res[i]);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		n_errors++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		is_final <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_byte(b, fin);
		n_bytes++;
	endtask

	task automatic send_seq(input logic [7:0] q [$]);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic send_str(input string s);
		logic [7:0] q [$];
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
		send_seq(q);
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (classify(c) != CL_WORD);
		return c;
	endfunction

	function automatic logic [7:0] any_but(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == x || c == y);
		return c;
	endfunction

	task automatic build_text(ref logic [7:0] q [$]);
		int target;
		int len;
		int r;
		logic [7:0] qc;
		string pairs;
		string singles;
		pairs = "!+-*:/><=^";
		singles = "&|[]{}().,;\\";
		q.delete();
		target = $urandom_range(1, 30);
		if ($urandom_range(0, 4) == 0) begin
			repeat (target) q.insert(q.size(), 8'($urandom_range(0, 255)));
			return;
		end
		while (q.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					len = $urandom_range(1, 6);
					repeat (len) q.insert(q.size(), word_char());
				end
				3, 4: begin
					q.insert(q.size(), pairs[$urandom_range(0, pairs.len() - 1)]);
					if ($urandom_range(0, 1))
						q.insert(q.size(), CH_EQ);
				end
				5: q.insert(q.size(), singles[$urandom_range(0, singles.len() - 1)]);
				6, 7: begin
					qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
					q.insert(q.size(), qc);
					len = $urandom_range(0, 8);
					repeat (len) begin
						r = $urandom_range(0, 9);
						if (r == 0) begin
							q.insert(q.size(), CH_NL);
						end else if (r == 1) begin
							q.insert(q.size(), CH_HASH);
							repeat ($urandom_range(0, 3))
								q.insert(q.size(), any_but(CH_NL, CH_NL));
							q.insert(q.size(), CH_NL);
						end else begin
							q.insert(q.size(), any_but(qc, CH_HASH));
						end
					end
					if ($urandom_range(0, 9) != 0)
						q.insert(q.size(), qc);
				end
				8: begin
					q.insert(q.size(), CH_HASH);
					repeat ($urandom_range(0, 6)) q.insert(q.size(), any_but(CH_NL, CH_NL));
					if ($urandom_range(0, 9) != 0)
						q.insert(q.size(), CH_NL);
				end
				default: q.insert(q.size(), $urandom_range(0, 1) ? CH_SPACE : CH_NL);
			endcase
		end
	endtask

	task automatic test_word_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(CH_SPACE, 1'b1);
	endtask

	task automatic test_operators();
		send_str("<=-x&^");
		send_str("+#\n=");
	endtask

	task automatic test_literals_and_comments();
		send_str("w'a#z\nb' \"q");
		send_str("#x");
	endtask

	task automatic test_random_texts(input int budget, input bit with_idle);
		logic [7:0] q [$];
		int start;
		idle_on = with_idle;
		start = n_bytes;
		while (n_bytes - start < budget) begin
			build_text(q);
			send_seq(q);
		end
	endtask

	always @(posedge clk) begin
		if (idle_on && stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{token_byte, byte_valid, token_end, text_done, last};
			if (token_q.size() == 0) begin
				report_mismatch("beat with nothing expected", got.token_byte, 8'h00);
			end else begin
				want = token_q.pop_front();
				if (got.token_byte !== want.token_byte)
					report_mismatch("token_byte", got.token_byte, want.token_byte);
				if (got.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
				if (got.token_end !== want.token_end)
					report_mismatch("token_end", 8'(got.token_end), 8'(want.token_end));
				if (got.text_done !== want.text_done)
					report_mismatch("text_done", 8'(got.text_done), 8'(want.text_done));
				if (got.last !== want.last)
					report_mismatch("last", 8'(got.last), 8'(want.last));
				n_checked++;
				if (want.token_end)
					n_tokens++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		tk_mode = MODE_NORMAL;
		tk_quote = 8'h00;
		tk_held = 8'h00;
		tk_held_v = 1'b0;
		tk_held_op = 1'b0;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		text_byte <= 8'h00;
		is_final <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_word_extremes();
		test_operators();
		test_literals_and_comments();
		test_random_texts(550, 1'b1);
		test_random_texts(150, 1'b0);
		in_valid <= 1'b0;

		while (token_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d texts, %0d source bytes in; %0d result beats checked, %0d tokens closed.",
			n_texts, n_bytes, n_checked, n_tokens);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
